// ===== sv/bmsc_pkg.sv =====
// Package for the multi-button event scanner: shared types, event codes,
// configuration register indexes and reset values. No dependencies.
package bmsc_pkg;

    // Buttons at this index or beyond never appear in a scan tick.
    localparam int MAX_SCAN = 8;

    // Depth of the result queue in front of the output ports.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;

    localparam logic [15:0] DOWN_TICKS_RST   = 16'd2;
    localparam logic [15:0] HOLD_TICKS_RST   = 16'd50;
    localparam logic [15:0] REPEAT_TICKS_RST = 16'd0;

    typedef enum logic [2:0] {
        CFG_BUTTON_COUNT     = 3'd0,
        CFG_PRESS_LEVEL_MASK = 3'd1,
        CFG_DOWN_TICKS       = 3'd2,
        CFG_HOLD_TICKS       = 3'd3,
        CFG_REPEAT_TICKS     = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        EV_CLICK_DOWN  = 3'd0,
        EV_HOLD        = 3'd1,
        EV_HOLD_REPEAT = 3'd2,
        EV_CLICK_UP    = 3'd3,
        EV_HOLD_UP     = 3'd4
    } t_event_code;

    typedef struct packed {
        logic [3:0]  button_count;
        logic [7:0]  press_level_mask;
        logic [15:0] down_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] repeat_ticks;
    } t_cfg;

    // One classified scan tick waiting in the front queue.
    typedef struct packed {
        logic       valid;
        logic [7:0] pressed;
    } t_tick;

    typedef struct packed {
        logic [2:0]  button_index;
        t_event_code event_code;
        logic        last_event;
    } t_result;

    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_status;

endpackage

// ===== sv/bmsc_front.sv =====
// Front part of the scanner: takes in scan ticks, turns pin levels into
// pressed bits and holds them in a two-entry queue. Depends on bmsc_pkg.
module bmsc_front
    import bmsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_pin_levels,
    input  logic [7:0] i_press_mask,
    output t_tick      o_tick,
    input  logic       i_pop
);

    logic [7:0] r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr;
    logic       w_rd;

    assign o_full = (r_count == 2'd2);
    assign w_wr   = i_push && !o_full;
    assign w_rd   = i_pop && (r_count != 2'd0);

    assign o_tick.valid   = (r_count != 2'd0);
    assign o_tick.pressed = r_slot[r_rd_ptr];

    // A button is pressed when its pin level matches its press level.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= ~(i_pin_levels ^ i_press_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== sv/bmsc_mod_unit.sv =====
// Bit-serial remainder unit: computes dividend modulo a 16-bit divisor, one
// dividend bit per cycle, MSB first. Depends on bmsc_pkg.
module bmsc_mod_unit
    import bmsc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_dividend,
    input  logic [15:0]            i_divisor,
    output t_mod_status            o_status
);

    localparam int STEP_W = $clog2(COUNT_WIDTH + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_steps;
    logic [COUNT_WIDTH-1:0] r_div;
    logic [15:0]            r_rem;
    logic [15:0]            r_divisor;
    logic [16:0]            w_trial;
    logic                   w_ge;
    logic [15:0]            n_rem;

    // The partial remainder stays below the divisor, so 16 bits hold it.
    assign w_trial = {r_rem, r_div[COUNT_WIDTH-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});
    assign n_rem   = w_ge ? 16'(w_trial - {1'b0, r_divisor}) : w_trial[15:0];

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == 16'd0);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div     <= i_dividend;
            r_rem     <= 16'd0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_div <= r_div << 1;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
            r_steps <= STEP_W'(COUNT_WIDTH);
        end else if (r_busy) begin
            r_steps <= r_steps - STEP_W'(1);
            if (r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== sv/bmsc_back.sv =====
// Back part of the scanner: walks the buttons of one tick, updates the press
// counters and emits events. Depends on bmsc_pkg and bmsc_mod_unit.
module bmsc_back
    import bmsc_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_tick   i_tick,
    output logic    o_tick_pop,
    output logic    o_res_push,
    output t_result o_res_data,
    input  logic    i_res_full
);

    localparam int SCAN  = (NUM_BUTTONS < MAX_SCAN) ? NUM_BUTTONS : MAX_SCAN;
    localparam int IDX_W = (SCAN > 1) ? $clog2(SCAN) : 1;
    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [3:0] SCAN_N = 4'(SCAN);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EVAL  = 4'b0010,
        S_MOD   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_back_state;

    t_back_state            r_state, n_state;
    logic [3:0]             r_idx, n_idx;
    logic [3:0]             r_active, n_active;
    logic [7:0]             r_pressed, n_pressed;
    logic                   r_pend_v, n_pend_v;
    t_result                r_pend, n_pend;
    logic [COUNT_WIDTH-1:0] r_cnt [SCAN];

    logic [COUNT_WIDTH-1:0] w_old;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic [CMP_W-1:0]       w_inc_x;
    logic [CMP_W-1:0]       w_old_x;
    logic [CMP_W-1:0]       w_down_x;
    logic [CMP_W-1:0]       w_hold_x;
    logic                   w_cnt_we;
    logic [COUNT_WIDTH-1:0] w_cnt_wd;
    logic                   w_ev_v;
    t_event_code            w_ev_code;
    logic                   w_adv;
    logic                   w_blocked;
    logic                   w_stall;
    logic                   w_mod_start;
    t_mod_status            w_mod;

    assign w_old    = r_cnt[r_idx[IDX_W-1:0]];
    assign w_inc    = w_old + COUNT_WIDTH'(1);
    assign w_inc_x  = CMP_W'(w_inc);
    assign w_old_x  = CMP_W'(w_old);
    assign w_down_x = CMP_W'(i_cfg.down_ticks);
    assign w_hold_x = CMP_W'(i_cfg.hold_ticks);

    // A new event can only be taken once the held one has room to leave.
    assign w_blocked = r_pend_v && i_res_full;

    bmsc_mod_unit #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_inc),
        .i_divisor  (i_cfg.repeat_ticks),
        .o_status   (w_mod)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_active    = r_active;
        n_pressed   = r_pressed;
        n_pend_v    = r_pend_v;
        n_pend      = r_pend;
        o_tick_pop  = 1'b0;
        o_res_push  = 1'b0;
        o_res_data  = '{r_pend.button_index, r_pend.event_code, 1'b0};
        w_cnt_we    = 1'b0;
        w_cnt_wd    = '0;
        w_ev_v      = 1'b0;
        w_ev_code   = EV_CLICK_DOWN;
        w_adv       = 1'b0;
        w_stall     = 1'b0;
        w_mod_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_tick.valid) begin
                    o_tick_pop = 1'b1;
                    n_pressed  = i_tick.pressed;
                    n_active   = (i_cfg.button_count > SCAN_N) ? SCAN_N
                                                               : i_cfg.button_count;
                    n_idx      = 4'd0;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_idx >= r_active) begin
                    n_state = r_pend_v ? S_FLUSH : S_IDLE;
                end else if (r_pressed[r_idx[2:0]]) begin
                    if (&w_old) begin
                        w_adv = 1'b1;
                    end else if (w_inc_x == w_down_x) begin
                        w_stall   = w_blocked;
                        w_ev_v    = 1'b1;
                        w_ev_code = EV_CLICK_DOWN;
                        w_cnt_we  = !w_stall;
                        w_cnt_wd  = w_inc;
                        w_adv     = !w_stall;
                    end else if (w_inc_x == w_hold_x) begin
                        w_stall   = w_blocked;
                        w_ev_v    = 1'b1;
                        w_ev_code = EV_HOLD;
                        w_cnt_we  = !w_stall;
                        w_cnt_wd  = w_inc;
                        w_adv     = !w_stall;
                    end else if (w_inc_x > w_hold_x && i_cfg.repeat_ticks != 16'd0) begin
                        w_cnt_we    = 1'b1;
                        w_cnt_wd    = w_inc;
                        w_mod_start = 1'b1;
                        n_state     = S_MOD;
                    end else begin
                        w_cnt_we = 1'b1;
                        w_cnt_wd = w_inc;
                        w_adv    = 1'b1;
                    end
                end else begin
                    if (w_old_x >= w_down_x && w_old_x < w_hold_x) begin
                        w_ev_v    = 1'b1;
                        w_ev_code = EV_CLICK_UP;
                    end else if (w_old_x >= w_hold_x) begin
                        w_ev_v    = 1'b1;
                        w_ev_code = EV_HOLD_UP;
                    end
                    w_stall  = w_ev_v && w_blocked;
                    w_cnt_we = !w_stall;
                    w_adv    = !w_stall;
                end
            end
            S_MOD: begin
                if (w_mod.done) begin
                    w_ev_v    = w_mod.zero;
                    w_ev_code = EV_HOLD_REPEAT;
                    w_stall   = w_mod.zero && w_blocked;
                    w_adv     = !w_stall;
                    if (!w_stall) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res_data = '{r_pend.button_index, r_pend.event_code, 1'b1};
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The held event leaves as soon as a later one of the same tick shows
        // up, so only the final one of the tick goes out marked as last.
        if (w_adv) begin
            n_idx = r_idx + 4'd1;
            if (w_ev_v) begin
                o_res_push = r_pend_v;
                n_pend_v   = 1'b1;
                n_pend     = '{r_idx[2:0], w_ev_code, 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_active  <= n_active;
        r_pressed <= n_pressed;
        r_pend    <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= 4'd0;
            r_pend_v <= 1'b0;
            for (int k = 0; k < SCAN; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            if (w_cnt_we) begin
                r_cnt[r_idx[IDX_W-1:0]] <= w_cnt_wd;
            end
        end
    end

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("event still held while waiting for a new tick");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= SCAN_N)
        else $error("scan index ran past the scanned buttons");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_mod_starts_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_start |=> (r_state == S_MOD))
        else $error("repeat check started without waiting for it");

endmodule

// ===== sv/bmsc_result_fifo.sv =====
// Result queue between the back part and the output ports of the scanner.
// Depends on bmsc_pkg.
module bmsc_result_fifo
    import bmsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    t_result              r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr;
    logic [RES_PTR_W-1:0] r_rd_ptr;
    logic [RES_PTR_W:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_count == (RES_PTR_W + 1)'(RES_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + RES_PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + RES_PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (RES_PTR_W + 1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (RES_PTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== sv/multi_button_event_scanner.sv =====
// Flow: a tick waits in the front queue until the idle back part takes it.
// The back part scans its buttons in turn and waits for the remainder unit on a repeat check.
// button_count is capped at 8; a tick with events also flushes its held event, and output stalls
// hold the scan. A tick yields up to 8 events.
// Reset: synchronous, active low; clears queues, counters and loads register defaults.
// Top level; depends on bmsc_pkg, bmsc_front, bmsc_back and bmsc_result_fifo.
module multi_button_event_scanner
    import bmsc_pkg::*;
#(
    parameter int NUM_BUTTONS = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_pin_levels,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_button_index,
    output logic [2:0]  o_event_code,
    output logic        o_last_event
);

    t_cfg    r_cfg;
    t_tick   w_tick;
    logic    w_tick_pop;
    logic    w_res_push;
    t_result w_res_in;
    logic    w_res_full;
    t_result w_res_out;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_count     <= 4'd0;
            r_cfg.press_level_mask <= 8'd0;
            r_cfg.down_ticks       <= DOWN_TICKS_RST;
            r_cfg.hold_ticks       <= HOLD_TICKS_RST;
            r_cfg.repeat_ticks     <= REPEAT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BUTTON_COUNT:     r_cfg.button_count     <= i_cfg_data[3:0];
                CFG_PRESS_LEVEL_MASK: r_cfg.press_level_mask <= i_cfg_data[7:0];
                CFG_DOWN_TICKS:       r_cfg.down_ticks       <= i_cfg_data;
                CFG_HOLD_TICKS:       r_cfg.hold_ticks       <= i_cfg_data;
                CFG_REPEAT_TICKS:     r_cfg.repeat_ticks     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front part classifies each tick at transfer time and queues the
    // pressed bits, so the input side keeps taking ticks until that queue is
    // full while the back part is still walking the buttons of an earlier one.
    bmsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_pin_levels (i_pin_levels),
        .i_press_mask (r_cfg.press_level_mask),
        .o_tick       (w_tick),
        .i_pop        (w_tick_pop)
    );

    // The back part owns the press counters and produces the events of a
    // tick in button order. It holds one event back until it knows whether
    // a later one follows, which is how the last event of a tick is marked.
    bmsc_back #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_tick     (w_tick),
        .o_tick_pop (w_tick_pop),
        .o_res_push (w_res_push),
        .o_res_data (w_res_in),
        .i_res_full (w_res_full)
    );

    // Results wait here until the consumer transfers them; the back part
    // only stalls once this queue is full.
    bmsc_result_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign o_button_index = w_res_out.button_index;
    assign o_event_code   = w_res_out.event_code;
    assign o_last_event   = w_res_out.last_event;

endmodule
